[hdl/eep_pkg.sv]
// Shared types and constants for the evicting entry pool.
package eep_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned HANDLE_W    = 8;
  localparam int unsigned STAMP_W     = 31;
  localparam int unsigned LIFE_W      = 31;
  localparam int unsigned GRANT_W     = 8;
  localparam int unsigned FREED_W     = 9;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_SWEEP = 2'd2
  } op_e;

  typedef struct packed {
    logic [LIFE_W-1:0]   lifetime;
    logic [STAMP_W-1:0]  stamp;
    logic [HANDLE_W-1:0] handle;
    op_e                 op;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [FREED_W-1:0] freed_count;
    logic [GRANT_W-1:0] granted;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

endpackage

[hdl/eep_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module eep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/eep_seq.sv]
// Link-list sequencer: link and entry memories, list heads, and the operation state machine.
module eep_seq import eep_pkg::*; #(
  parameter int unsigned POOL_ENTRIES = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic sweep_enable_i,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int unsigned AW = $clog2(POOL_ENTRIES);
  localparam int unsigned LW = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned DW = STAMP_W + LIFE_W;
  localparam logic [LW-1:0] NONE = LW'(POOL_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(POOL_ENTRIES - 1);

  typedef enum logic [9:0] {
    ST_INIT    = 10'b0000000001,
    ST_IDLE    = 10'b0000000010,
    ST_AL_RD   = 10'b0000000100,
    ST_AL_LINK = 10'b0000001000,
    ST_AL_HEAD = 10'b0000010000,
    ST_EV_CHK  = 10'b0000100000,
    ST_FR_CHK  = 10'b0001000000,
    ST_SW_CHK  = 10'b0010000000,
    ST_REL_RET = 10'b0100000000,
    ST_DONE    = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [LW-1:0]      free_head_q, free_head_d;
  logic [LW-1:0]      head_q, head_d;
  logic [LW-1:0]      tail_q, tail_d;
  logic [LW-1:0]      nxt_q, nxt_d;
  logic [AW-1:0]      cur_q, cur_d;
  logic [AW-1:0]      init_q, init_d;
  logic               first_q, first_d;
  logic [STAMP_W-1:0] oldest_q, oldest_d;
  req_t               req_q, req_d;
  res_t               res_q, res_d;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               nx_we;
  logic [AW-1:0]      nx_waddr;
  logic [LW-1:0]      nx_wdata;
  logic [LW-1:0]      nx_rd;
  logic               pv_we;
  logic [AW-1:0]      pv_waddr;
  logic [LW:0]        pv_wdata;
  logic [LW:0]        pv_rd;
  logic               dt_we;
  logic [DW-1:0]      dt_wdata;
  logic [DW-1:0]      dt_rd;

  logic               fix_en;
  logic [LW-1:0]      fix_p;
  logic [LW-1:0]      fix_n;
  logic [STAMP_W-1:0] dt_stamp;
  logic [LIFE_W-1:0]  dt_life;
  logic               expired;
  logic               in_range;

  assign fix_p    = pv_rd[LW-1:0];
  assign fix_n    = nx_rd;
  assign dt_stamp = dt_rd[DW-1:LIFE_W];
  assign dt_life  = dt_rd[LIFE_W-1:0];
  assign expired  = {1'b0, req_q.stamp} > ({1'b0, dt_stamp} + {1'b0, dt_life});
  assign in_range = 32'(req_i.handle) < 32'(POOL_ENTRIES);
  assign rd_addr  = cur_d;

  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    head_d      = head_q;
    tail_d      = tail_q;
    nxt_d       = nxt_q;
    cur_d       = cur_q;
    init_d      = init_q;
    first_d     = first_q;
    oldest_d    = oldest_q;
    req_d       = req_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    nx_we       = 1'b0;
    nx_waddr    = cur_q;
    nx_wdata    = '0;
    pv_we       = 1'b0;
    pv_waddr    = cur_q;
    pv_wdata    = '0;
    dt_we       = 1'b0;
    dt_wdata    = {req_q.stamp, req_q.lifetime};
    fix_en      = 1'b0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        nx_we    = 1'b1;
        nx_waddr = init_q;
        nx_wdata = LW'(init_q) + LW'(1);
        pv_we    = 1'b1;
        pv_waddr = init_q;
        pv_wdata = {1'b0, NONE};
        init_d   = init_q + AW'(1);
        if (init_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d = req_i;
          res_d = '0;
          unique case (req_i.op)
            OP_ALLOC: begin
              if (free_head_q != NONE) begin
                cur_d   = free_head_q[AW-1:0];
                rd_en   = 1'b1;
                state_d = ST_AL_LINK;
              end else if (tail_q != NONE) begin
                cur_d   = tail_q[AW-1:0];
                rd_en   = 1'b1;
                first_d = 1'b1;
                state_d = ST_EV_CHK;
              end else begin
                state_d = ST_DONE;
              end
            end
            OP_FREE: begin
              if (in_range) begin
                cur_d   = AW'(req_i.handle);
                rd_en   = 1'b1;
                state_d = ST_FR_CHK;
              end else begin
                res_d.status = 1'b1;
                state_d      = ST_DONE;
              end
            end
            OP_SWEEP: begin
              if (sweep_enable_i && head_q != NONE) begin
                cur_d   = head_q[AW-1:0];
                rd_en   = 1'b1;
                state_d = ST_SW_CHK;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_AL_RD: begin
        if (free_head_q != NONE) begin
          cur_d   = free_head_q[AW-1:0];
          rd_en   = 1'b1;
          state_d = ST_AL_LINK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_AL_LINK: begin
        free_head_d = nx_rd;
        nx_we       = 1'b1;
        nx_wdata    = head_q;
        pv_we       = 1'b1;
        pv_wdata    = {1'b1, NONE};
        dt_we       = 1'b1;
        state_d     = ST_AL_HEAD;
      end
      ST_AL_HEAD: begin
        if (head_q != NONE) begin
          pv_we    = 1'b1;
          pv_waddr = head_q[AW-1:0];
          pv_wdata = {1'b1, LW'(cur_q)};
        end else begin
          tail_d = LW'(cur_q);
        end
        head_d        = LW'(cur_q);
        res_d.granted = GRANT_W'(cur_q);
        state_d       = ST_DONE;
      end
      ST_EV_CHK: begin
        if (first_q || dt_stamp == oldest_q) begin
          fix_en            = 1'b1;
          first_d           = 1'b0;
          oldest_d          = dt_stamp;
          res_d.freed_count = res_q.freed_count + FREED_W'(1);
          state_d           = ST_REL_RET;
        end else begin
          state_d = ST_AL_RD;
        end
      end
      ST_FR_CHK: begin
        if (pv_rd[LW]) begin
          fix_en  = 1'b1;
          state_d = ST_REL_RET;
        end else begin
          res_d.status = 1'b1;
          state_d      = ST_DONE;
        end
      end
      ST_SW_CHK: begin
        if (expired) begin
          fix_en            = 1'b1;
          nxt_d             = nx_rd;
          res_d.freed_count = res_q.freed_count + FREED_W'(1);
          state_d           = ST_REL_RET;
        end else if (nx_rd != NONE) begin
          cur_d = nx_rd[AW-1:0];
          rd_en = 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_REL_RET: begin
        nx_we       = 1'b1;
        nx_wdata    = free_head_q;
        pv_we       = 1'b1;
        pv_wdata    = {1'b0, NONE};
        free_head_d = LW'(cur_q);
        unique case (req_q.op)
          OP_ALLOC: begin
            if (tail_q != NONE) begin
              cur_d   = tail_q[AW-1:0];
              rd_en   = 1'b1;
              state_d = ST_EV_CHK;
            end else begin
              state_d = ST_AL_RD;
            end
          end
          OP_SWEEP: begin
            if (nxt_q != NONE) begin
              cur_d   = nxt_q[AW-1:0];
              rd_en   = 1'b1;
              state_d = ST_SW_CHK;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fix_en) begin
      if (fix_p != NONE) begin
        nx_we    = 1'b1;
        nx_waddr = fix_p[AW-1:0];
        nx_wdata = fix_n;
      end else begin
        head_d = fix_n;
      end
      if (fix_n != NONE) begin
        pv_we    = 1'b1;
        pv_waddr = fix_n[AW-1:0];
        pv_wdata = {1'b1, fix_p};
      end else begin
        tail_d = fix_p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      free_head_q <= '0;
      head_q      <= NONE;
      tail_q      <= NONE;
      init_q      <= '0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      init_q      <= init_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q    <= nxt_d;
    cur_q    <= cur_d;
    oldest_q <= oldest_d;
    req_q    <= req_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

  eep_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_ENTRIES)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (nx_rd)
  );

  eep_ram #(
    .WIDTH (LW + 1),
    .DEPTH (POOL_ENTRIES)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_waddr),
    .wdata_i (pv_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (pv_rd)
  );

  eep_ram #(
    .WIDTH (DW),
    .DEPTH (POOL_ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dt_we),
    .waddr_i (cur_q),
    .wdata_i (dt_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (dt_rd)
  );

endmodule

[hdl/evicting_entry_pool.sv]
// Top level of the evicting entry pool: stream ports, sweep enable register, result register.
//
//   channel  | direction | transfer when             | payload
//   ---------+-----------+---------------------------+--------------------------------------
//   s_axis   | in        | s_axis_tvalid & tready    | op, handle, stamp, lifetime
//   m_axis   | out       | m_axis_tvalid & tready    | granted, freed_count, status
//   cfg      | in        | cfg_we_i                  | sweep_enable
//
// After reset an init pass over all POOL_ENTRIES entries builds the free chain; no transfer is taken then.
// Allocate takes the head of the free chain; when it is empty it first evicts entries from
// the tail of the active list while they share the stamp of the tail entry. Free returns
// one active entry. The sweep frees each expired entry of the active list. Each step is
// bounded by one read and one write on the link memories.
// A held result stalls only the end of the following item.
module evicting_entry_pool import eep_pkg::*; #(
  parameter int unsigned POOL_ENTRIES = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // op[1:0], handle[9:2], stamp[40:10], lifetime[71:41]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // granted[7:0], freed_count[16:8], status[17], zero[23:18]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i
);

  logic sweep_enable_q;
  logic out_valid_q, out_valid_d;
  res_t out_q;
  res_t res;
  logic res_valid;
  logic res_ready;
  req_t req;

  assign req       = req_t'(s_axis_tdata);
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_enable_q <= 1'b1;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sweep_enable_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_q};

  eep_seq #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sweep_enable_i (sweep_enable_q),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .req_i          (req),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

endmodule
